// ----- src/nor_flash_array_model_macros.svh -----
// Assertion macros used by the NOR flash array model controller.
`ifndef NOR_FLASH_ARRAY_MODEL_MACROS_SVH
`define NOR_FLASH_ARRAY_MODEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/nfa_pkg.sv -----
// Package: sizes, command codes and transfer/control structs for the NOR flash array model.
package nfa_pkg;

   // Array geometry
   localparam int MEM_BYTES    = 262144;
   localparam int SECTOR_BYTES = 4096;
   localparam int BLOCK_BYTES  = 65536;
   localparam int MEM_AW       = $clog2(MEM_BYTES);
   localparam int SEC_AW       = $clog2(SECTOR_BYTES);
   localparam int BLK_AW       = $clog2(BLOCK_BYTES);

   localparam logic [32:0] MEM_LIMIT   = 33'(MEM_BYTES);
   localparam logic [32:0] BLOCK_LIMIT = 33'(BLOCK_BYTES);

   localparam logic [7:0] ERASED_VALUE = 8'hFF;

   // Command codes
   localparam logic [2:0] CMD_READ         = 3'd0;
   localparam logic [2:0] CMD_PROGRAM      = 3'd1;
   localparam logic [2:0] CMD_ERASE_SECTOR = 3'd2;
   localparam logic [2:0] CMD_ERASE_BLOCK  = 3'd3;
   localparam logic [2:0] CMD_ERASE_RANGE  = 3'd4;

   // Request transfer
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] address;
      logic [7:0]  write_byte;
      logic [31:0] length;
   } req_type;

   // Response transfer
   typedef struct packed {
      logic [7:0] read_byte;
      logic       status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // latch accepted request
      logic sweep_load;  // load erase pointer and count
      logic sweep_step;  // write one erased byte, advance
      logic prog_wr;     // write back programmed byte
      logic rsp_load;    // capture response
      logic rsp_bad;     // response status is invalid
      logic rsp_use_mem; // response byte from array read
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic bad;        // request fails its checks
      logic nop;        // zero-length range erase
      logic is_erase;
      logic is_read;
      logic sweep_done; // current byte is last of the sweep
   } dp_stat_type;

endpackage

// ----- src/nfa_datapath.sv -----
// Datapath: request register and checks, flash array memory, erase sweep, response register.
module nfa_datapath (
   input  logic                clock,
   input  logic                reset,
   input  nfa_pkg::req_type     req_data,
   input  nfa_pkg::dp_cmd_type  dp_cmd,
   output nfa_pkg::dp_stat_type dp_stat,
   output nfa_pkg::rsp_type     rsp_data
);

   nfa_pkg::req_type req_ff, req_in;
   nfa_pkg::rsp_type rsp_ff, rsp_in;

   logic [nfa_pkg::MEM_AW-1:0] ptr_ff, ptr_in;
   logic [nfa_pkg::MEM_AW-1:0] cnt_ff, cnt_in;
   logic [7:0]                 rd_data_ff;

   logic [7:0] mem [nfa_pkg::MEM_BYTES];

   logic [32:0]                addr_ext;
   logic [32:0]                range_end;
   logic [32:0]                blk_end;
   logic [31:0]                len_m1;
   logic                       in_range;
   logic                       sec_aligned;
   logic                       blk_aligned;
   logic [nfa_pkg::MEM_AW-1:0] sweep_start;
   logic [nfa_pkg::MEM_AW-1:0] sweep_cnt;
   logic [nfa_pkg::MEM_AW-1:0] acc_addr;
   logic                       mem_we;
   logic [nfa_pkg::MEM_AW-1:0] mem_wa;
   logic [7:0]                 mem_wd;

   // Request register
   always_comb begin
      req_in = req_ff;
      if (dp_cmd.load) begin
         req_in = req_data;
      end
   end

   // Request checks, sums taken without wrap
   always_comb begin
      addr_ext    = {1'b0, req_ff.address};
      range_end   = addr_ext + {1'b0, req_ff.length};
      blk_end     = addr_ext + nfa_pkg::BLOCK_LIMIT;
      len_m1      = req_ff.length - 32'd1;
      in_range    = addr_ext < nfa_pkg::MEM_LIMIT;
      sec_aligned = req_ff.address[nfa_pkg::SEC_AW-1:0] == '0;
      blk_aligned = req_ff.address[nfa_pkg::BLK_AW-1:0] == '0;
      acc_addr    = req_ff.address[nfa_pkg::MEM_AW-1:0];
      sweep_start = {req_ff.address[nfa_pkg::MEM_AW-1:nfa_pkg::SEC_AW],
                     {nfa_pkg::SEC_AW{1'b0}}};

      dp_stat.bad        = 1'b0;
      dp_stat.nop        = 1'b0;
      dp_stat.is_erase   = 1'b0;
      dp_stat.is_read    = req_ff.cmd == nfa_pkg::CMD_READ;
      dp_stat.sweep_done = cnt_ff == '0;
      sweep_cnt          = nfa_pkg::MEM_AW'(nfa_pkg::SECTOR_BYTES - 1);

      case (req_ff.cmd)
         nfa_pkg::CMD_READ, nfa_pkg::CMD_PROGRAM: begin
            dp_stat.bad = !in_range;
         end
         nfa_pkg::CMD_ERASE_SECTOR: begin
            dp_stat.is_erase = 1'b1;
            dp_stat.bad      = !sec_aligned || !in_range;
         end
         nfa_pkg::CMD_ERASE_BLOCK: begin
            dp_stat.is_erase = 1'b1;
            dp_stat.bad      = !blk_aligned || (blk_end > nfa_pkg::MEM_LIMIT);
            sweep_cnt        = nfa_pkg::MEM_AW'(nfa_pkg::BLOCK_BYTES - 1);
         end
         nfa_pkg::CMD_ERASE_RANGE: begin
            // Walk covers every sector from the start's sector, length rounded up
            dp_stat.is_erase = 1'b1;
            dp_stat.nop      = req_ff.length == '0;
            dp_stat.bad      = !dp_stat.nop && (range_end > nfa_pkg::MEM_LIMIT);
            sweep_cnt        = len_m1[nfa_pkg::MEM_AW-1:0] |
                               nfa_pkg::MEM_AW'(nfa_pkg::SECTOR_BYTES - 1);
         end
         default: begin
            dp_stat.bad = 1'b1;
         end
      endcase
   end

   // Sweep pointer and remaining count
   always_comb begin
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      if (dp_cmd.sweep_load) begin
         ptr_in = sweep_start;
         cnt_in = sweep_cnt;
      end else if (dp_cmd.sweep_step) begin
         ptr_in = ptr_ff + nfa_pkg::MEM_AW'(1);
         cnt_in = cnt_ff - nfa_pkg::MEM_AW'(1);
      end
   end

   // Memory write port select
   always_comb begin
      mem_we = dp_cmd.sweep_step || dp_cmd.prog_wr;
      mem_wa = dp_cmd.prog_wr ? acc_addr : ptr_ff;
      mem_wd = dp_cmd.prog_wr ? (rd_data_ff & req_ff.write_byte) : nfa_pkg::ERASED_VALUE;
   end

   // Response capture
   always_comb begin
      rsp_in = rsp_ff;
      if (dp_cmd.rsp_load) begin
         rsp_in.read_byte = dp_cmd.rsp_use_mem ? rd_data_ff : 8'd0;
         rsp_in.status    = dp_cmd.rsp_bad;
      end
   end

   // Sweep registers: reset starts the clearing pass over the whole array
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= nfa_pkg::MEM_AW'(nfa_pkg::MEM_BYTES - 1);
      end else begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Flash array: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[acc_addr];
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/nfa_ctrl.sv -----
// Controller: state machine sequencing checks, array accesses, erase sweeps and responses.
`include "nor_flash_array_model_macros.svh"

module nfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output nfa_pkg::dp_cmd_type  dp_cmd,
   input  nfa_pkg::dp_stat_type dp_stat
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_READ  = 5'b01000,
      ST_SWEEP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      dp_cmd       = '0;
      case (state_ff)
         ST_INIT: begin
            dp_cmd.sweep_step = 1'b1;
            if (dp_stat.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dp_stat.bad || dp_stat.nop) begin
               dp_cmd.rsp_load = 1'b1;
               dp_cmd.rsp_bad  = dp_stat.bad;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else if (dp_stat.is_erase) begin
               dp_cmd.sweep_load = 1'b1;
               state_in          = ST_SWEEP;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // array byte is in the read register now
            dp_cmd.rsp_load    = 1'b1;
            dp_cmd.rsp_use_mem = dp_stat.is_read;
            dp_cmd.prog_wr     = !dp_stat.is_read;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_SWEEP: begin
            dp_cmd.sweep_step = 1'b1;
            if (dp_stat.sweep_done) begin
               dp_cmd.rsp_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Checks
   `NFA_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE,
      "response strobe outside idle")
   `NFA_ASSERT_NEXT(a_accept_to_check, clock, reset, start && !busy, state_ff == ST_CHECK,
      "accepted request did not enter check")
   `NFA_ASSERT_NEXT(a_sweep_holds, clock, reset,
      state_ff == ST_SWEEP && !dp_stat.sweep_done,
      state_ff == ST_SWEEP && !rsp_valid_ff,
      "erase sweep ended early")

endmodule

// ----- src/nor_flash_array_model.sv -----
// Top level: byte-wide NOR flash array with read, program and sector/block/range erase.
//
// Usage:
//  - Request channel: drive req_data and raise start; the request transfers at a
//    rising edge where start is high and busy is low.
//  - Response channel: rsp_data is valid for exactly one cycle while rsp_valid is
//    high; the receiver must take it then, it cannot stall the block.
//  - Read and program: the request passes the check and read states before the
//    response; the next request may transfer in the same cycle the response shows.
//  - Erase: one array byte is written per cycle through the single write port;
//    a sector erase writes 4096 bytes, a block erase 65536; a range erase covers
//    its length rounded up to whole sectors.
//  - Rejected requests and zero-length range erases answer straight from the check state.
//  - Reset: the block runs a clearing pass that writes 0xFF to all 262144 bytes,
//    one per cycle; busy stays high until the pass ends.
//  - A program ANDs write_byte into the stored byte; read_byte is zero except on
//    a successful read; status 1 flags a bad address, alignment, range or command code.
module nor_flash_array_model (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nfa_pkg::req_type req_data,
   output logic             rsp_valid,
   output nfa_pkg::rsp_type rsp_data
);

   nfa_pkg::dp_cmd_type  dp_cmd;
   nfa_pkg::dp_stat_type dp_stat;

   nfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   nfa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the NOR flash array model: directed and random transfers checked against a byte mirror.
module testbench;
   import nfa_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1700;
   // Longest silent stretch is the clearing pass after reset (one byte written per cycle)
   localparam int STALL_LIMIT  = 4 * MEM_BYTES;
   localparam int SETTLE_CYCLES = 20;
   // Bytes the random part may spend on valid erases
   localparam int ERASE_BUDGET = 300000;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Mirror of the array plus the queue of responses still owed by the block
   class flash_image;
      bit [7:0] cells [MEM_BYTES];
      bit [32:0] cursor;
      rsp_type awaited_q [$];
      int mismatches;

      function new();
         foreach (cells[i]) cells[i] = ERASED_VALUE;
         cursor = '0;
         mismatches = 0;
      endfunction

      // Aligned region erase; refuses misaligned or out-of-array regions
      function bit wipe(longint unsigned base, longint unsigned size);
         longint unsigned a;
         if (base % size != 0) return 1'b0;
         if (base + size > MEM_BYTES) return 1'b0;
         for (a = base; a < base + size; a++) cells[a] = ERASED_VALUE;
         return 1'b1;
      endfunction

      // Range erase: walk a cursor, erasing block, aligned sector or the
      // sector holding the cursor, advancing by the erased length
      function bit wipe_range(longint unsigned first, longint unsigned len);
         longint unsigned stop;
         longint unsigned cur;
         longint unsigned remaining;
         longint unsigned stride;
         bit ok;
         if (len == 0) return 1'b1;
         stop = first + len;
         if (stop > MEM_BYTES) return 1'b0;
         cur = first;
         while (cur < stop) begin
            remaining = stop - cur;
            if (cur % BLOCK_BYTES == 0 && remaining >= BLOCK_BYTES) begin
               stride = BLOCK_BYTES;
               ok = wipe(cur, BLOCK_BYTES);
            end else if (cur % SECTOR_BYTES == 0 && remaining >= SECTOR_BYTES) begin
               stride = SECTOR_BYTES;
               ok = wipe(cur, SECTOR_BYTES);
            end else begin
               stride = SECTOR_BYTES;
               ok = wipe(cur - cur % SECTOR_BYTES, SECTOR_BYTES);
            end
            if (!ok) begin
               cursor = 33'(cur);
               return 1'b0;
            end
            cur += stride;
         end
         cursor = 33'(cur);
         return 1'b1;
      endfunction

      // Apply an accepted request to the mirror and queue its response
      function void accept_request(req_type item);
         rsp_type want;
         longint unsigned addr;
         addr = item.address;
         want.read_byte = 8'h00;
         want.status = STATUS_OK;
         case (item.cmd)
            CMD_READ: begin
               if (addr < MEM_BYTES) want.read_byte = cells[addr];
               else want.status = STATUS_BAD;
            end
            CMD_PROGRAM: begin
               if (addr < MEM_BYTES) cells[addr] = cells[addr] & item.write_byte;
               else want.status = STATUS_BAD;
            end
            CMD_ERASE_SECTOR: want.status = wipe(addr, SECTOR_BYTES) ? STATUS_OK : STATUS_BAD;
            CMD_ERASE_BLOCK:  want.status = wipe(addr, BLOCK_BYTES) ? STATUS_OK : STATUS_BAD;
            CMD_ERASE_RANGE:  want.status = wipe_range(addr, item.length) ? STATUS_OK : STATUS_BAD;
            default: want.status = STATUS_BAD;
         endcase
         awaited_q.push_back(want);
      endfunction

      // Compare a response with the oldest one owed
      function void check_reply(rsp_type got);
         rsp_type want;
         if (awaited_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got read_byte %02h status %0b",
                     $time, got.read_byte, got.status);
            mismatches++;
            return;
         end
         want = awaited_q.pop_front();
         if (got.read_byte !== want.read_byte) begin
            $display("%0t: read_byte expected %02h, got %02h", $time, want.read_byte,
                     got.read_byte);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0b, got %0b", $time, want.status, got.status);
            mismatches++;
         end
      endfunction

      function int owed();
         return awaited_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   flash_image image;
   int  idle_cycles = 0;
   int  erase_left = ERASE_BUDGET;
   bit  steady_run = 1'b0;
   logic [31:0] recent_q [$];

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   nor_flash_array_model dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Response side: every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) image.check_reply(rsp_data);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type mk(logic [2:0] cmd, logic [31:0] address,
                                  logic [7:0] write_byte, logic [31:0] length);
      req_type item;
      item.cmd = cmd;
      item.address = address;
      item.write_byte = write_byte;
      item.length = length;
      return item;
   endfunction

   // Mostly short gaps, a few long ones, none during a steady run
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Present one request, wait for its transfer, then optionally idle
   task automatic issue(input req_type item, input int gap);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      image.accept_request(item);
      if (gap > 0) begin
         start <= 1'b0;
         req_data <= mk(3'($urandom), $urandom, 8'($urandom), $urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every response has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (image.owed() != 0);
   endtask

   // Addresses favor recently programmed bytes and the first and last sectors
   function automatic logic [31:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && recent_q.size() > 0) return recent_q[$urandom_range(0, recent_q.size() - 1)];
      if (r < 65) return ($urandom_range(0, 1) ? 0 : MEM_BYTES - 2 * SECTOR_BYTES)
                        + $urandom_range(0, 2 * SECTOR_BYTES - 1);
      if (r < 88) return $urandom_range(0, MEM_BYTES - 1);
      return $urandom_range(MEM_BYTES, 32'hFFFF_FFFF);
   endfunction

   function automatic req_type random_request();
      req_type item;
      int r;
      int len;
      item = mk(CMD_READ, $urandom, 8'($urandom), $urandom);
      r = $urandom_range(0, 99);
      if (r < 45) begin
         item.address = pick_address();
      end else if (r < 83) begin
         item.cmd = CMD_PROGRAM;
         item.address = pick_address();
         case ($urandom_range(0, 5))
            3: item.write_byte = ~(8'h01 << $urandom_range(0, 7));
            4: item.write_byte = 8'h00;
            5: item.write_byte = 8'hFF;
            default: ;
         endcase
         if (item.address < MEM_BYTES) begin
            recent_q.push_back(item.address);
            if (recent_q.size() > 16) void'(recent_q.pop_front());
         end
      end else if (r < 89) begin
         item.cmd = CMD_ERASE_SECTOR;
         if ($urandom_range(0, 3) == 0 && erase_left >= SECTOR_BYTES) begin
            case ($urandom_range(0, 2))
               0: item.address = 32'($urandom_range(0, 2)) << SEC_AW;
               1: item.address = 32'(MEM_BYTES / SECTOR_BYTES - 1 - $urandom_range(0, 1)) << SEC_AW;
               default: item.address = 32'($urandom_range(0, MEM_BYTES / SECTOR_BYTES - 1)) << SEC_AW;
            endcase
            erase_left -= SECTOR_BYTES;
         end else if ($urandom_range(0, 1)) begin
            item.address = $urandom_range(0, MEM_BYTES - 1) | (32'h1 << $urandom_range(0, SEC_AW - 1));
         end else begin
            item.address = 32'($urandom_range(MEM_BYTES / SECTOR_BYTES, 32'hF_FFFF)) << SEC_AW;
         end
      end else if (r < 93) begin
         item.cmd = CMD_ERASE_BLOCK;
         if ($urandom_range(0, 15) == 0 && erase_left >= BLOCK_BYTES) begin
            item.address = 32'($urandom_range(0, MEM_BYTES / BLOCK_BYTES - 1)) << BLK_AW;
            erase_left -= BLOCK_BYTES;
         end else if ($urandom_range(0, 1)) begin
            item.address = $urandom_range(0, MEM_BYTES - 1) | (32'h1 << $urandom_range(0, BLK_AW - 1));
         end else begin
            item.address = 32'($urandom_range(MEM_BYTES / BLOCK_BYTES, 32'hFFFF)) << BLK_AW;
         end
      end else if (r < 98) begin
         item.cmd = CMD_ERASE_RANGE;
         case ($urandom_range(0, 9))
            0, 1: item.length = 0;
            2: begin
               // wild address and length; rare sums that fit become zero length
               if (longint'(item.address) + longint'(item.length) <= MEM_BYTES) item.length = 0;
            end
            3: begin
               // just past the end of the array
               len = $urandom_range(1, 3 * SECTOR_BYTES);
               item.length = len;
               item.address = MEM_BYTES - len + $urandom_range(1, 64);
            end
            default: begin
               len = $urandom_range(1, ($urandom_range(0, 7) == 0) ? BLOCK_BYTES + 2 * SECTOR_BYTES
                                                                   : 3 * SECTOR_BYTES);
               if (erase_left < len + 2 * SECTOR_BYTES) begin
                  item.length = 0;
               end else begin
                  item.length = len;
                  item.address = $urandom_range(0, MEM_BYTES - len);
                  case ($urandom_range(0, 2))
                     1: item.address &= ~32'(SECTOR_BYTES - 1);
                     2: item.address &= ~32'(BLOCK_BYTES - 1);
                     default: ;
                  endcase
                  erase_left -= len + 2 * SECTOR_BYTES;
               end
            end
         endcase
      end else begin
         item.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      end
      return item;
   endfunction

   initial begin
      int served;
      image = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reads and programs, including AND behavior and out-of-range addresses
      issue(mk(CMD_READ, 0, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_PROGRAM, 0, 8'hA5, $urandom), gap_len());
      issue(mk(CMD_PROGRAM, 0, 8'h5A, $urandom), gap_len());
      issue(mk(CMD_READ, 0, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_PROGRAM, MEM_BYTES - 1, 8'h00, $urandom), gap_len());
      issue(mk(CMD_READ, MEM_BYTES, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_PROGRAM, 32'hFFFF_FFFF, 8'h00, $urandom), gap_len());
      // Sector erase: misaligned, aligned but past the end, valid
      issue(mk(CMD_ERASE_SECTOR, 1, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_ERASE_SECTOR, 32'hFFFF_F000, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_ERASE_SECTOR, 0, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_READ, 0, 8'($urandom), $urandom), gap_len());
      // Block erase: misaligned, past the end, last block
      issue(mk(CMD_ERASE_BLOCK, SECTOR_BYTES, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_ERASE_BLOCK, MEM_BYTES, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_ERASE_BLOCK, MEM_BYTES - BLOCK_BYTES, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_READ, MEM_BYTES - 1, 8'($urandom), $urandom), gap_len());
      // Range erase: zero length anywhere, sums past the end without wrap
      issue(mk(CMD_ERASE_RANGE, 32'hFFFF_FFFF, 8'($urandom), 0), gap_len());
      issue(mk(CMD_ERASE_RANGE, 32'hFFFF_FFFF, 8'($urandom), 32'hFFFF_FFFF), gap_len());
      issue(mk(CMD_ERASE_RANGE, MEM_BYTES - 1, 8'($urandom), 2), gap_len());
      // Unaligned cursor spills into the next sector beyond the requested end
      issue(mk(CMD_PROGRAM, 2 * SECTOR_BYTES + 100, 8'h00, $urandom), gap_len());
      issue(mk(CMD_ERASE_RANGE, SECTOR_BYTES + 10, 8'($urandom), SECTOR_BYTES + 1), gap_len());
      issue(mk(CMD_READ, 2 * SECTOR_BYTES + 100, 8'($urandom), $urandom), gap_len());
      // Block, then aligned sector, then partial sector
      issue(mk(CMD_ERASE_RANGE, 0, 8'($urandom), BLOCK_BYTES + SECTOR_BYTES + 1), gap_len());
      // Unused command codes
      issue(mk(CMD_UNUSED_FIRST, $urandom, 8'($urandom), $urandom), gap_len());
      issue(mk(CMD_UNUSED_LAST, $urandom, 8'($urandom), $urandom), gap_len());
      drain();

      // Random part with periodic steady runs and drain pauses
      for (served = 0; served < RANDOM_ITEMS; served++) begin
         if (served % 150 == 0) steady_run = ($urandom_range(0, 3) == 0);
         if (served % 400 == 399) drain();
         issue(random_request(), gap_len());
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (image.mismatches == 0 && image.owed() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
